// File: hw/rtl/epc_pkg.sv
// Shared types and constants for the event performance counter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package epc_pkg;
    localparam int WINDOW_DEFAULT = 16;
    typedef enum logic [1:0] {
        MODE_INC  = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_TIME = 2'd2,
        MODE_HIT  = 2'd3
    } t_mode;
endpackage
`default_nettype wire

// File: hw/rtl/event_performance_counter_top.sv
// Event performance counter: level, two per-second rate rings, timing mean, hit counts.
// Flow: slot reduction, ring update and scan, then shared-divider passes for both rate
// averages and, for a timing item, the mean; the snapshot then goes to the output register.
// A new item is taken only once the previous one is through, and a waiting result holds
// back the next input too. After reset the rings clear before the first item is accepted.
// Reset is synchronous, active low, and clears all counters and flags.
`timescale 1ns / 1ps
`default_nettype none
module event_performance_counter_top #(
    parameter int WINDOW_SECONDS = epc_pkg::WINDOW_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [15:0] i_amount,
    input  wire logic [23:0] i_sample_ms,
    input  wire logic        i_was_hit,
    input  wire logic [31:0] i_now_sec,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_level,
    output logic [39:0]      o_inc_rate_avg,
    output logic [39:0]      o_dec_rate_avg,
    output logic [23:0]      o_timing_mean_ms,
    output logic [31:0]      o_hits,
    output logic [31:0]      o_accesses,
    output logic [3:0]       o_seen_flags
);
    import epc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIVI, S_DIVD, S_DIVM, S_OUT} t_state;

    t_state      r_state;
    logic [1:0]  r_mode;
    logic [23:0] r_samp;
    logic [31:0] r_level, r_hits, r_acc, r_cnt;
    logic [23:0] r_mean;
    logic [3:0]  r_flags;
    logic [39:0] r_iavg, r_davg;
    logic        r_idone, r_ddone, r_first;
    logic        r_ring_go, r_div_go;
    logic [63:0] r_num;
    logic [32:0] r_den;
    logic [31:0] r_out_level, r_out_hits, r_out_acc;
    logic [39:0] r_out_iavg, r_out_davg;
    logic [23:0] r_out_mean;
    logic [3:0]  r_out_flags;
    logic        w_accept, w_idone, w_ddone, w_div_done;
    logic        w_iclr, w_dclr, w_out_free;
    logic [37:0] w_itot, w_dtot;
    logic [6:0]  w_ilive, w_dlive;
    logic [63:0] w_quot;
    logic [63:0] w_prod;

    assign w_accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || w_iclr || w_dclr;
    assign w_out_free = !o_valid || !i_stall;
    assign w_prod = {40'd0, r_mean} * {32'd0, r_cnt};

    epc_ring #(.WINDOW(WINDOW_SECONDS)) u_inc (
        .i_clk, .i_rst_n, .i_start(r_ring_go), .i_upd(r_mode == MODE_INC),
        .i_amount(r_num[15:0]), .i_now(r_num[47:16]), .o_done(w_idone),
        .o_clearing(w_iclr), .o_total(w_itot), .o_live(w_ilive));
    epc_ring #(.WINDOW(WINDOW_SECONDS)) u_dec (
        .i_clk, .i_rst_n, .i_start(r_ring_go), .i_upd(r_mode == MODE_DEC),
        .i_amount(r_num[15:0]), .i_now(r_num[47:16]), .o_done(w_ddone),
        .o_clearing(w_dclr), .o_total(w_dtot), .o_live(w_dlive));
    epc_div u_div (
        .i_clk, .i_rst_n, .i_start(r_div_go), .i_num(r_num), .i_den(r_den),
        .o_done(w_div_done), .o_quot(w_quot));

    // Sequencer with scalar state updates and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_level <= '0; r_hits <= '0; r_acc <= '0; r_cnt <= '0;
            r_mean <= '0; r_flags <= '0;
            r_ring_go <= 1'b0; r_div_go <= 1'b0;
            r_idone <= 1'b0; r_ddone <= 1'b0; r_first <= 1'b0;
        end else begin
            r_ring_go <= (r_state == S_IDLE) && w_accept;
            r_div_go <= r_first &&
                        (r_state == S_DIVI || r_state == S_DIVD || r_state == S_DIVM);
            o_valid <= (r_state == S_OUT) || (o_valid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode <= i_mode;
                        r_samp <= i_sample_ms;
                        r_num <= {16'd0, i_now_sec, i_amount};
                        r_idone <= 1'b0;
                        r_ddone <= 1'b0;
                        r_state <= S_SCAN;
                        r_flags <= r_flags | (4'd1 << i_mode);
                        case (i_mode)
                            MODE_INC: r_level <= r_level + {16'd0, i_amount};
                            MODE_DEC: r_level <= r_level - {16'd0, i_amount};
                            MODE_HIT: begin
                                r_acc <= r_acc + 32'd1;
                                if (i_was_hit) r_hits <= r_hits + 32'd1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_idone) r_idone <= 1'b1;
                    if (w_ddone) r_ddone <= 1'b1;
                    if ((r_idone || w_idone) && (r_ddone || w_ddone)) begin
                        r_state <= S_DIVI;
                        r_first <= 1'b1;
                    end
                end
                S_DIVI, S_DIVD, S_DIVM: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        if (r_state == S_DIVI) begin
                            r_num <= {18'd0, w_itot, 8'd0};
                            r_den <= {26'd0, w_ilive};
                        end else if (r_state == S_DIVD) begin
                            r_num <= {18'd0, w_dtot, 8'd0};
                            r_den <= {26'd0, w_dlive};
                        end else begin
                            r_num <= w_prod + {40'd0, r_samp};
                            r_den <= {1'b0, r_cnt} + 33'd1;
                        end
                    end else if (w_div_done) begin
                        r_first <= 1'b1;
                        if (r_state == S_DIVI) begin
                            r_iavg <= (r_den == '0) ? '0 : w_quot[39:0];
                            r_state <= S_DIVD;
                        end else if (r_state == S_DIVD) begin
                            r_davg <= (r_den == '0) ? '0 : w_quot[39:0];
                            r_state <= (r_mode == MODE_TIME) ? S_DIVM : S_OUT;
                        end else begin
                            r_mean <= w_quot[23:0];
                            r_cnt <= r_cnt + 32'd1;
                            r_state <= S_OUT;
                        end
                    end
                end
                // The snapshot moves to the output register once the previous one is taken.
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_level <= r_level;
                        r_out_iavg <= r_iavg;
                        r_out_davg <= r_davg;
                        r_out_mean <= r_mean;
                        r_out_hits <= r_hits;
                        r_out_acc <= r_acc;
                        r_out_flags <= r_flags;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_level = r_out_level;
    assign o_inc_rate_avg = r_out_iavg;
    assign o_dec_rate_avg = r_out_davg;
    assign o_timing_mean_ms = r_out_mean;
    assign o_hits = r_out_hits;
    assign o_accesses = r_out_acc;
    assign o_seen_flags = r_out_flags;
endmodule
`default_nettype wire

// File: hw/rtl/epc_ring.sv
// One per-second bucket ring: a stamp/count memory with read-modify-write
// of one slot, a byte-wise slot reduction and a sequential scan that sums the live buckets.
// Uses epc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module epc_ring #(
    parameter int WINDOW = epc_pkg::WINDOW_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_upd,
    input  wire logic [15:0] i_amount,
    input  wire logic [31:0] i_now,
    output logic             o_done,
    output logic             o_clearing,
    output logic [37:0]      o_total,
    output logic [6:0]       o_live
);
    import epc_pkg::*;
    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [31:0] WIN32 = 32'(WINDOW);
    localparam logic [AW:0] WIN_M = WIN32[AW:0];

    typedef enum logic [2:0] {S_IDLE, S_CLR, S_MOD, S_RD, S_WR, S_SCAN, S_LAST} t_state;

    logic [63:0] r_mem [WINDOW];
    logic [63:0] r_rdata;
    t_state      r_state;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_slot;
    logic        r_upd;
    logic [31:0] r_now;
    logic [15:0] r_amt;
    logic [37:0] r_total;
    logic [6:0]  r_live;
    logic [31:0] r_digits;
    logic [1:0]  r_step;

    logic [AW-1:0] w_raddr;
    logic        w_we;
    logic [AW-1:0] w_waddr;
    logic [63:0] w_wdata;
    logic [31:0] w_age;
    logic [31:0] w_sum;
    logic [AW-1:0] w_shift_res [WINDOW];
    logic [AW-1:0] w_byte_res [256];
    logic [AW:0]   w_res_sum;
    logic [AW-1:0] w_res_next;

    // Constant residue tables: (r * 256) mod WINDOW and byte mod WINDOW.
    for (genvar g = 0; g < WINDOW; g++) begin : g_shift_res
        assign w_shift_res[g] = AW'((g * 256) % WINDOW);
    end
    for (genvar g = 0; g < 256; g++) begin : g_byte_res
        assign w_byte_res[g] = AW'(g % WINDOW);
    end

    // Slot number: now mod WINDOW, folded in one byte a cycle from the top byte down.
    assign w_res_sum = {1'b0, w_shift_res[r_slot]} + {1'b0, w_byte_res[r_digits[31:24]]};
    assign w_res_next = (w_res_sum >= WIN_M) ? AW'(w_res_sum - WIN_M) : w_res_sum[AW-1:0];

    always_comb begin
        w_raddr = r_idx[AW-1:0];
        if (r_state == S_RD) w_raddr = r_slot;
    end

    // Memory port: one read and one write a cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    assign w_sum = (r_rdata[63:32] != r_now) ? {16'd0, r_amt}
                                             : r_rdata[31:0] + {16'd0, r_amt};
    assign w_age = r_now - r_rdata[63:32];

    always_comb begin
        w_we = 1'b0;
        w_waddr = r_slot;
        w_wdata = {r_now, w_sum};
        if (r_state == S_CLR) begin
            w_we = 1'b1;
            w_waddr = r_idx[AW-1:0];
            w_wdata = '0;
        end else if (r_state == S_WR && r_upd) begin
            w_we = 1'b1;
        end
    end

    // Sequencer: clear after reset, then reduce the slot, update it when i_upd is set and scan the ring.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= (r_state == S_LAST);
            unique case (r_state)
                S_CLR: begin
                    if (r_idx == CW'(WINDOW - 1)) begin
                        r_state <= S_IDLE;
                        r_idx <= '0;
                    end else r_idx <= r_idx + 1'b1;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_MOD;
                        r_slot <= '0;
                        r_digits <= i_now;
                        r_step <= '0;
                        r_upd <= i_upd;
                        r_now <= i_now;
                        r_amt <= i_amount;
                    end
                end
                S_MOD: begin
                    r_slot <= w_res_next;
                    r_digits <= {r_digits[23:0], 8'd0};
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) r_state <= S_RD;
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    r_state <= S_SCAN;
                    r_idx <= '0;
                    r_total <= '0;
                    r_live <= '0;
                end
                S_SCAN: begin
                    // r_rdata holds entry r_idx-1 except on the first scan cycle.
                    if (r_idx != '0 && w_age <= WIN32) begin
                        r_total <= r_total + {6'd0, r_rdata[31:0]};
                        r_live <= r_live + 7'd1;
                    end
                    if (r_idx == CW'(WINDOW)) r_state <= S_LAST;
                    else r_idx <= r_idx + 1'b1;
                end
                S_LAST: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clearing = (r_state == S_CLR);
    assign o_total = r_total;
    assign o_live  = r_live;
endmodule
`default_nettype wire

// File: hw/rtl/epc_div.sv
// Restoring divider, one quotient bit a cycle, 64-bit dividend and 33-bit divisor.
// No dependencies on other files.
`timescale 1ns / 1ps
`default_nettype none
module epc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [32:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quot
);
    logic [63:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_sh;
    logic [34:0] w_diff;

    assign w_sh = {r_rem[32:0], r_q[63]};
    assign w_diff = {1'b0, w_sh} - {2'b0, r_den};

    // Shift-subtract iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && (r_cnt == 7'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_q <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= 7'd0;
            end else if (r_busy) begin
                if (!w_diff[34]) begin
                    r_rem <= w_diff[33:0];
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule
`default_nettype wire

// File: sim/tb_event_performance_counter_top.sv
// Self-checking testbench for the event performance counter: directed and random events,
// with a built-in predictor of level, both rate rings, timing mean and hit counts.
// Depends on epc_pkg and event_performance_counter_top.
`timescale 1ns / 1ps
module tb_event_performance_counter_top;
    import epc_pkg::*;

    localparam int WIN = WINDOW_DEFAULT;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] amount;
        logic [23:0] sample_ms;
        logic        was_hit;
        logic [31:0] now_sec;
    } t_event;

    typedef struct packed {
        logic [31:0] level;
        logic [39:0] inc_avg;
        logic [39:0] dec_avg;
        logic [23:0] mean;
        logic [31:0] hits;
        logic [31:0] accesses;
        logic [3:0]  flags;
    } t_snapshot;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  in_mode = '0;
    logic [15:0] in_amount = '0;
    logic [23:0] in_sample = '0;
    logic        in_hit = 1'b0;
    logic [31:0] in_now = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] out_level;
    logic [39:0] out_inc_avg;
    logic [39:0] out_dec_avg;
    logic [23:0] out_mean;
    logic [31:0] out_hits;
    logic [31:0] out_accesses;
    logic [3:0]  out_flags;
    t_snapshot   got;

    event_performance_counter_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_mode(in_mode), .i_amount(in_amount), .i_sample_ms(in_sample),
        .i_was_hit(in_hit), .i_now_sec(in_now), .o_valid(out_valid), .i_stall(out_stall),
        .o_level(out_level), .o_inc_rate_avg(out_inc_avg), .o_dec_rate_avg(out_dec_avg),
        .o_timing_mean_ms(out_mean), .o_hits(out_hits), .o_accesses(out_accesses),
        .o_seen_flags(out_flags)
    );

    assign got = {out_level, out_inc_avg, out_dec_avg, out_mean, out_hits, out_accesses,
                  out_flags};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state.
    logic [31:0] p_level;
    logic [31:0] p_inc_stamp [WIN];
    logic [31:0] p_inc_count [WIN];
    logic [31:0] p_dec_stamp [WIN];
    logic [31:0] p_dec_count [WIN];
    logic [23:0] p_mean;
    logic [31:0] p_samples;
    logic [31:0] p_hits;
    logic [31:0] p_accesses;
    logic [3:0]  p_flags;

    t_event    pending_events[$];
    t_snapshot expected_snapshots[$];
    int        mismatches = 0;
    int        accepted = 0;
    int        checked = 0;
    int        hold_sender = 0;
    bit        stim_done = 0;
    int        in_gap = 0;
    int        out_gap = 0;

    // Average of the live buckets in one ring, as a Q.8 quotient.
    function automatic logic [39:0] ring_average(input logic [31:0] stamps [WIN],
                                                 input logic [31:0] counts [WIN],
                                                 input logic [31:0] now);
        logic [63:0] total;
        logic [63:0] live;
        logic [31:0] age;
        total = 0;
        live = 0;
        for (int i = 0; i < WIN; i++) begin
            age = now - stamps[i];
            if (age <= WIN) begin
                total += counts[i];
                live++;
            end
        end
        if (live == 0) return '0;
        return 40'((total << 8) / live);
    endfunction

    // Apply one event to the predictor and queue the snapshot it yields.
    task automatic predict_snapshot(input t_event ev);
        logic [63:0] acc;
        logic [63:0] n;
        int slot;
        t_snapshot s;
        slot = ev.now_sec % WIN;
        case (ev.mode)
            MODE_INC: begin
                p_flags[0] = 1'b1;
                p_level += ev.amount;
                p_inc_count[slot] = (p_inc_stamp[slot] != ev.now_sec) ? 32'(ev.amount)
                                    : p_inc_count[slot] + ev.amount;
                p_inc_stamp[slot] = ev.now_sec;
            end
            MODE_DEC: begin
                p_flags[1] = 1'b1;
                p_level -= ev.amount;
                p_dec_count[slot] = (p_dec_stamp[slot] != ev.now_sec) ? 32'(ev.amount)
                                    : p_dec_count[slot] + ev.amount;
                p_dec_stamp[slot] = ev.now_sec;
            end
            MODE_TIME: begin
                p_flags[2] = 1'b1;
                n = p_samples;
                acc = 64'(p_mean) * n + ev.sample_ms;
                p_mean = 24'(acc / (n + 1));
                p_samples += 1;
            end
            default: begin
                p_flags[3] = 1'b1;
                if (ev.was_hit) p_hits += 1;
                p_accesses += 1;
            end
        endcase
        s.level = p_level;
        s.inc_avg = ring_average(p_inc_stamp, p_inc_count, ev.now_sec);
        s.dec_avg = ring_average(p_dec_stamp, p_dec_count, ev.now_sec);
        s.mean = p_mean;
        s.hits = p_hits;
        s.accesses = p_accesses;
        s.flags = p_flags;
        expected_snapshots.push_back(s);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    function automatic t_event make_event(input t_mode m, input logic [31:0] now);
        t_event ev;
        ev.mode = m;
        ev.amount = 16'($urandom);
        ev.sample_ms = 24'($urandom);
        ev.was_hit = 1'($urandom);
        ev.now_sec = now;
        return ev;
    endfunction

    // Driver: presents queued events, with random gaps between them.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predict_snapshot({t_mode'(in_mode), in_amount, in_sample, in_hit, in_now});
                accepted++;
                in_gap = pick_gap();
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0 && !(in_valid && !in_stall && in_gap == 0)) begin
                    in_gap--;
                    in_valid <= 1'b0;
                end else if (hold_sender > 0 && accepted >= hold_sender &&
                             expected_snapshots.size() != 0) begin
                    in_valid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    if (hold_sender > 0 && accepted >= hold_sender) hold_sender = 0;
                    {in_mode, in_amount, in_sample, in_hit, in_now} <=
                        pending_events.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each snapshot with the oldest prediction and drives stall.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_snapshots.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected snapshot %p", got);
                end else begin
                    t_snapshot want;
                    want = expected_snapshots.pop_front();
                    checked++;
                    if (want !== got) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch on snapshot %0d: expected %p, got %p",
                                     checked, want, got);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                out_gap = pick_gap();
                out_stall <= (out_gap > 0);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_event ev;
        logic [31:0] now;
        int burst;
        p_level = 0; p_mean = 0; p_samples = 0; p_hits = 0; p_accesses = 0; p_flags = 0;
        for (int i = 0; i < WIN; i++) begin
            p_inc_stamp[i] = 0; p_inc_count[i] = 0; p_dec_stamp[i] = 0; p_dec_count[i] = 0;
        end

        // Directed: reset-state buckets live near time zero, extremes of every field,
        // repeated seconds in one bucket, future stamps, wrap of the level.
        ev = make_event(MODE_HIT, 0); ev.was_hit = 1'b0; pending_events.push_back(ev);
        ev = make_event(MODE_INC, 0); ev.amount = 16'hFFFF; pending_events.push_back(ev);
        ev = make_event(MODE_INC, 0); ev.amount = 16'hFFFF; pending_events.push_back(ev);
        ev = make_event(MODE_DEC, 1); ev.amount = 16'hFFFF; pending_events.push_back(ev);
        ev = make_event(MODE_DEC, 1); ev.amount = 16'hFFFF; pending_events.push_back(ev);
        ev = make_event(MODE_DEC, 2); ev.amount = 16'hFFFF; pending_events.push_back(ev);
        ev = make_event(MODE_INC, 32'(WIN)); ev.amount = 0; pending_events.push_back(ev);
        ev = make_event(MODE_INC, 32'(WIN + 1)); ev.amount = 1; pending_events.push_back(ev);
        ev = make_event(MODE_TIME, 32'(WIN + 1)); ev.sample_ms = 24'hFFFFFF;
        pending_events.push_back(ev);
        ev = make_event(MODE_TIME, 5); ev.sample_ms = 0; pending_events.push_back(ev);
        ev = make_event(MODE_TIME, 5); ev.sample_ms = 24'hFFFFFF; pending_events.push_back(ev);
        ev = make_event(MODE_HIT, 3); ev.was_hit = 1'b1; pending_events.push_back(ev);
        ev = make_event(MODE_INC, 32'hFFFF_FFFF); ev.amount = 16'hFFFF;
        pending_events.push_back(ev);
        ev = make_event(MODE_INC, 32'hFFFF_FFF0); pending_events.push_back(ev);
        ev = make_event(MODE_DEC, 32'h8000_0000); pending_events.push_back(ev);
        ev = make_event(MODE_INC, 100); pending_events.push_back(ev);
        ev = make_event(MODE_INC, 80); pending_events.push_back(ev);
        ev = make_event(MODE_HIT, 200); ev.was_hit = 1'b0; pending_events.push_back(ev);

        // Random: mostly advancing time with bursts in the same second, some jumps.
        now = $urandom;
        while (pending_events.size() < 1320) begin
            case ($urandom_range(0, 9))
                0: now = $urandom;
                1: now = now - $urandom_range(1, 40);
                2, 3: now = now + $urandom_range(1, 2 * WIN);
                default: now = now + $urandom_range(0, 1);
            endcase
            burst = $urandom_range(1, 4);
            for (int k = 0; k < burst; k++)
                pending_events.push_back(make_event(t_mode'($urandom_range(0, 3)), now));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        hold_sender = 600;
        stim_done = 1;
    end

    // End of run: everything sent and checked, then a short quiet period.
    initial begin
        wait (stim_done);
        wait (pending_events.size() == 0 && !in_valid && expected_snapshots.size() == 0);
        repeat (400) @(posedge clk);
        $display("Checked %0d snapshots over %0d events: all modes, ring aging and wrap.",
                 checked, accepted);
        if (mismatches == 0 && expected_snapshots.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("Mismatches: %0d, snapshots left over: %0d", mismatches,
                     expected_snapshots.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("Timeout with %0d snapshots outstanding", expected_snapshots.size());
        $display("*** FAILED ***");
        $finish;
    end
endmodule
